// ===== sv/drcvs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and CRC helpers for the dual record validate and select block.
package drcvs_pkg;

   localparam int unsigned HDR_BYTES = 12;
   localparam int unsigned HDR_BITS  = HDR_BYTES * 8;
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAGIC    = 3'd0,
      CSR_VERSION  = 3'd1,
      CSR_COMMIT   = 3'd2,
      CSR_INACTIVE = 3'd3,
      CSR_ACTIVE   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_UNKNOWN  = 2'd0,
      SEL_INACTIVE = 2'd1,
      SEL_ACTIVE   = 2'd2
   } sel_code_type;

   typedef struct packed {
      logic [31:0] expected_magic;
      logic [15:0] expected_version;
      logic [31:0] expected_commit;
      logic [15:0] inactive_code;
      logic [15:0] active_code;
   } cfg_type;

   // one stored record as seen by a lane
   typedef struct packed {
      logic [31:0] magic;
      logic [15:0] version;
      logic [15:0] status;
      logic [31:0] generation;
      logic [31:0] stored_crc;
      logic [31:0] commit;
   } rec_type;

   typedef struct packed {
      logic [31:0] first_magic;
      logic [15:0] first_version;
      logic [15:0] first_status;
      logic [31:0] first_generation;
      logic [31:0] first_stored_crc;
      logic [31:0] first_commit;
      logic [31:0] second_magic;
      logic [15:0] second_version;
      logic [15:0] second_status;
      logic [31:0] second_generation;
      logic [31:0] second_stored_crc;
      logic [31:0] second_commit;
   } req_type;

   typedef struct packed {
      logic        first_ok;
      logic        second_ok;
      logic        found;
      logic [1:0]  selected_result;
      logic        chose_second;
      logic [31:0] first_computed_crc;
      logic [31:0] second_computed_crc;
   } rsp_type;

   // what a lane hands to the merging stage
   typedef struct packed {
      logic        vld;
      logic        ok;
      logic [31:0] crc;
      logic [31:0] generation;
      logic [15:0] status;
   } lane_out_type;

   // reflected CRC-32, one byte, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // header bytes are magic, version, status, generation, MSB first
   function automatic logic [7:0] hdr_byte(input rec_type rec, input int unsigned idx);
      logic [HDR_BITS-1:0] hdr;
      hdr = {rec.magic, rec.version, rec.status, rec.generation};
      return hdr[HDR_BITS-1-8*idx -: 8];
   endfunction

endpackage

// ===== sv/drcvs_lane.sv =====
`timescale 1ns / 1ps
// One record lane: byte-per-stage CRC-32 pipeline followed by the record checks.
module drcvs_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  drcvs_pkg::rec_type     in_rec,
   input  drcvs_pkg::cfg_type     cfg,
   output drcvs_pkg::lane_out_type lane_out
);
   import drcvs_pkg::*;

   localparam int unsigned LastStage = HDR_BYTES - 1;

   logic [HDR_BYTES-1:0] vld_ff;
   logic [HDR_BYTES-1:0] vld_in;
   logic [31:0]          crc_ff [HDR_BYTES];
   logic [31:0]          crc_in [HDR_BYTES];
   rec_type              rec_ff [HDR_BYTES];
   rec_type              rec_in [HDR_BYTES];

   logic [31:0] final_crc;
   rec_type     last_rec;
   logic        status_ok;

   for (genvar k = 0; k < HDR_BYTES; k++) begin : g_stage
      if (k == 0) begin : g_head
         always_comb begin
            vld_in[k] = in_valid;
            rec_in[k] = in_rec;
            crc_in[k] = crc_byte(CRC_INIT, hdr_byte(in_rec, k));
         end
      end else begin : g_body
         always_comb begin
            vld_in[k] = vld_ff[k-1];
            rec_in[k] = rec_ff[k-1];
            crc_in[k] = crc_byte(crc_ff[k-1], hdr_byte(rec_ff[k-1], k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         crc_ff <= crc_in;
         rec_ff <= rec_in;
      end
   end

   always_comb begin
      last_rec  = rec_ff[LastStage];
      final_crc = crc_ff[LastStage] ^ CRC_INIT;
      status_ok = (last_rec.status == cfg.inactive_code) ||
                  (last_rec.status == cfg.active_code);
      lane_out.vld        = vld_ff[LastStage];
      lane_out.crc        = final_crc;
      lane_out.generation = last_rec.generation;
      lane_out.status     = last_rec.status;
      lane_out.ok         = (last_rec.magic == cfg.expected_magic) &&
                            (last_rec.version == cfg.expected_version) &&
                            (last_rec.commit == cfg.expected_commit) &&
                            status_ok && (final_crc == last_rec.stored_crc);
   end

endmodule

// ===== sv/drcvs_merge.sv =====
`timescale 1ns / 1ps
// Merging stage: picks the newest valid record and registers the result beat.
module drcvs_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  drcvs_pkg::lane_out_type first_lane,
   input  drcvs_pkg::lane_out_type second_lane,
   input  drcvs_pkg::cfg_type      cfg,
   output logic                    rsp_valid,
   output drcvs_pkg::rsp_type      rsp_data
);
   import drcvs_pkg::*;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   logic [31:0] gen_diff;
   logic        pick_second;
   logic        found;
   logic [15:0] pick_status;

   always_comb begin
      gen_diff    = first_lane.generation - second_lane.generation;
      found       = first_lane.ok || second_lane.ok;
      // wraparound compare: second wins if first is not ok, or if strictly newer
      pick_second = second_lane.ok && (!first_lane.ok || gen_diff[31]);
      pick_status = pick_second ? second_lane.status : first_lane.status;

      rsp_in.first_ok            = first_lane.ok;
      rsp_in.second_ok           = second_lane.ok;
      rsp_in.found               = found;
      rsp_in.chose_second        = pick_second;
      rsp_in.first_computed_crc  = first_lane.crc;
      rsp_in.second_computed_crc = second_lane.crc;
      if (!found) begin
         rsp_in.selected_result = SEL_UNKNOWN;
      end else if (pick_status == cfg.inactive_code) begin
         rsp_in.selected_result = SEL_INACTIVE;
      end else begin
         rsp_in.selected_result = SEL_ACTIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= first_lane.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/dual_record_crc_validate_select_top.sv =====
`timescale 1ns / 1ps
// Top level of the dual record CRC validate and select block.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_data  (req_type)
//   rsp      out        rsp_valid / rsp_ready     rsp_data  (rsp_type)
//   csr      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// One beat per cycle sustained while results are taken; 13 register stages: one
// CRC stage per header byte in each of the two record lanes (12) plus the
// registered merging stage.
// The whole pipeline advances when the output register is empty or being taken;
// a stalled result holds every stage, and req_ready follows that advance.
// Reset is synchronous and restores the register defaults; csr is always ready.
module dual_record_crc_validate_select_top (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  drcvs_pkg::req_type                         req_data,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output drcvs_pkg::rsp_type                         rsp_data,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [drcvs_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [31:0]                                csr_wdata
);
   import drcvs_pkg::*;

   cfg_type      cfg_ff;
   logic         advance;
   rec_type      first_rec;
   rec_type      second_rec;
   lane_out_type first_lane;
   lane_out_type second_lane;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_magic   <= 32'd0;
         cfg_ff.expected_version <= 16'd0;
         cfg_ff.expected_commit  <= 32'd0;
         cfg_ff.inactive_code    <= 16'd0;
         cfg_ff.active_code      <= 16'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAGIC:    cfg_ff.expected_magic   <= csr_wdata;
            CSR_VERSION:  cfg_ff.expected_version <= csr_wdata[15:0];
            CSR_COMMIT:   cfg_ff.expected_commit  <= csr_wdata;
            CSR_INACTIVE: cfg_ff.inactive_code    <= csr_wdata[15:0];
            CSR_ACTIVE:   cfg_ff.active_code      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      first_rec.magic       = req_data.first_magic;
      first_rec.version     = req_data.first_version;
      first_rec.status      = req_data.first_status;
      first_rec.generation  = req_data.first_generation;
      first_rec.stored_crc  = req_data.first_stored_crc;
      first_rec.commit      = req_data.first_commit;
      second_rec.magic      = req_data.second_magic;
      second_rec.version    = req_data.second_version;
      second_rec.status     = req_data.second_status;
      second_rec.generation = req_data.second_generation;
      second_rec.stored_crc = req_data.second_stored_crc;
      second_rec.commit     = req_data.second_commit;
   end

   drcvs_lane u_first_lane (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_rec   (first_rec),
      .cfg      (cfg_ff),
      .lane_out (first_lane)
   );

   drcvs_lane u_second_lane (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_rec   (second_rec),
      .cfg      (cfg_ff),
      .lane_out (second_lane)
   );

   drcvs_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .first_lane  (first_lane),
      .second_lane (second_lane),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule
